// File: rtl/lbp_pkg.sv
// Loop branch profiler package: item types, status codes, controller states,
// control/status structs and default sizes. No dependencies.

package lbp_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 32;
    localparam int ADDR_BITS_DEF  = 48;

    localparam int IN_ADDR_W = 48;
    localparam int OUT_CNT_W = 32;

    // result status codes
    localparam logic [1:0] STATUS_HIT   = 2'd0;
    localparam logic [1:0] STATUS_ALLOC = 2'd1;
    localparam logic [1:0] STATUS_DROP  = 2'd2;

    typedef struct packed {
        logic [IN_ADDR_W-1:0] branch_addr;
        logic                 taken;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [3:0]           slot;
        logic [OUT_CNT_W-1:0] seen_count;
        logic [OUT_CNT_W-1:0] invocations;
        logic [OUT_CNT_W-1:0] mean_trips;
        logic [OUT_CNT_W-1:0] change_count;
        logic [OUT_CNT_W-1:0] trip_count;
        logic [OUT_CNT_W-1:0] running_iters;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_FINISH
    } lbp_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic rd;
        logic calc;
        logic commit;
    } lbp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic full;
        logic need_div;
        logic div_done;
    } lbp_sts_t;

endpackage

// File: rtl/loop_branch_profiler_core.sv
// Loop branch profiler top level: controller plus datapath.
// Depends on lbp_pkg, lbp_ctrl, lbp_datapath (which holds lbp_divider).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_ready  | in_data  (in_item_t: addr, taken)
//  out     | output    | out_valid / out_ready| out_data (out_item_t: status,
//          |           |                      |  slot and six counters)
//
// One item is worked on at a time; in_ready is high only while idle, which
// includes the time a finished result waits in the output register.
// Steps from accept to result: tag scan (one tag read per cycle, until a hit
// or until every used slot has been compared), then read, update and commit
// (a dropped event goes straight to commit), with a divide step between
// update and commit when the branch is not taken.
// Reset clears only the fill count and control state; slots are allocated
// in order and never freed, so no clearing pass over the memories is needed.
// A stalled output holds the result; the block waits in its commit step
// only if a second result is ready before the first is taken.

module loop_branch_profiler_core
    import lbp_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    lbp_cmd_t cmd;
    lbp_sts_t sts;

    // sequencer: one state per step of an item
    lbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // tables, counters, divider and result register
    lbp_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

// File: rtl/lbp_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on lbp_pkg for the default width.

module lbp_divider
    import lbp_pkg::*;
#(
    parameter int W = COUNT_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = CW'(W);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            if (cnt_reg == CW'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/lbp_datapath.sv
// Profiler datapath: tag and counter memories, fill count, tag scan,
// counter update, mean divider and result register.
// Depends on lbp_pkg and lbp_divider.

module lbp_datapath
    import lbp_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  lbp_cmd_t  cmd,
    output lbp_sts_t  sts,
    output out_item_t out_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == CMAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
        logic [63:0] ext;
        ext    = 64'(v);
        to_out = ext[OUT_CNT_W-1:0];
    endfunction

    // storage
    logic [ADDR_BITS-1:0]  tag_mem    [ENTRIES];
    logic [COUNT_BITS-1:0] seen_mem   [ENTRIES];
    logic [COUNT_BITS-1:0] iter_mem   [ENTRIES];
    logic [COUNT_BITS-1:0] inv_mem    [ENTRIES];
    logic [COUNT_BITS-1:0] last_mem   [ENTRIES];
    logic [COUNT_BITS-1:0] mean_mem   [ENTRIES];
    logic [COUNT_BITS-1:0] chg_mem    [ENTRIES];

    logic [CNT_W-1:0]      used_reg;

    // captured item
    logic [ADDR_BITS-1:0]  addr_reg;
    logic                  taken_reg;
    logic [63:0]           addr_ext;

    // scan pipeline
    logic [CNT_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  cmp_live_reg;
    logic [ADDR_BITS-1:0]  tag_q_reg;

    logic [IDX_W-1:0]      slot_reg;
    logic [1:0]            kind_reg;

    // counters read at slot
    logic [COUNT_BITS-1:0] seen_q_reg, iter_q_reg, inv_q_reg;
    logic [COUNT_BITS-1:0] last_q_reg, mean_q_reg, chg_q_reg;

    // updated counters
    logic [COUNT_BITS-1:0] seen_n_reg, iter_n_reg, inv_n_reg;
    logic [COUNT_BITS-1:0] last_n_reg, chg_n_reg, mean_o_reg;
    logic                  ge_reg;

    logic [COUNT_BITS-1:0] seen_b, iter_b, inv_b, last_b, mean_b, chg_b;
    logic [COUNT_BITS-1:0] iter_inc, inv_inc, chg_inc;
    logic [COUNT_BITS-1:0] dividend, mean_new;
    logic [COUNT_BITS-1:0] quotient, remainder;
    logic                  ge;
    logic                  div_done;
    logic                  hit;
    logic                  miss;
    logic                  full;

    out_item_t             out_reg;
    out_item_t             drop_item;
    logic [7:0]            slot_ext;

    assign addr_ext = 64'(in_data.branch_addr);

    assign hit  = cmp_live_reg && (tag_q_reg == addr_reg);
    assign miss = !cmp_live_reg && (rd_idx_reg >= used_reg);
    assign full = (used_reg == CNT_W'(ENTRIES));

    assign sts.hit      = hit;
    assign sts.miss     = miss;
    assign sts.full     = full;
    assign sts.need_div = !taken_reg;
    assign sts.div_done = div_done;

    // a freshly allocated slot starts with all counters at zero
    always_comb
    begin
        if (kind_reg == STATUS_ALLOC)
        begin
            seen_b = '0;
            iter_b = '0;
            inv_b  = '0;
            last_b = '0;
            mean_b = '0;
            chg_b  = '0;
        end
        else
        begin
            seen_b = seen_q_reg;
            iter_b = iter_q_reg;
            inv_b  = inv_q_reg;
            last_b = last_q_reg;
            mean_b = mean_q_reg;
            chg_b  = chg_q_reg;
        end
        iter_inc = sat_inc(iter_b);
        inv_inc  = sat_inc(inv_b);
        chg_inc  = ((last_b != iter_inc) && (last_b != '0)) ? sat_inc(chg_b) : chg_b;
        ge       = (iter_inc >= mean_b);
        dividend = ge ? (iter_inc - mean_b) : (mean_b - iter_inc);
    end

    lbp_divider #(
        .W (COUNT_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.calc && !taken_reg),
        .dividend  (dividend),
        .divisor   (inv_inc),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // mean + floor((trip - mean) / inv), rounding toward minus infinity
    always_comb
    begin
        if (taken_reg)
            mean_new = mean_o_reg;
        else if (ge_reg)
            mean_new = mean_o_reg + quotient;
        else
            mean_new = mean_o_reg - quotient - COUNT_BITS'(remainder != '0);
    end

    // dropped event: flagged record, every other field zero
    always_comb
    begin
        drop_item        = '0;
        drop_item.status = STATUS_DROP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else if (cmd.commit && (kind_reg == STATUS_ALLOC))
            used_reg <= used_reg + 1'b1;
    end

    // scan and capture registers; cmp_live is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg   <= '0;
            cmp_live_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            rd_idx_reg   <= '0;
            cmp_live_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_live_reg <= (rd_idx_reg < used_reg);
            if (rd_idx_reg < used_reg)
                rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg  <= addr_ext[ADDR_BITS-1:0];
            taken_reg <= in_data.taken;
        end
        if (cmd.scan)
        begin
            if (rd_idx_reg < used_reg)
            begin
                tag_q_reg   <= tag_mem[rd_idx_reg[IDX_W-1:0]];
                cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
            end
            if (hit)
            begin
                slot_reg <= cmp_idx_reg;
                kind_reg <= STATUS_HIT;
            end
            else if (miss)
            begin
                slot_reg <= used_reg[IDX_W-1:0];
                kind_reg <= full ? STATUS_DROP : STATUS_ALLOC;
            end
        end
    end

    // counter memories: one read port (read step), one write port (commit)
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            seen_q_reg <= seen_mem[slot_reg];
            iter_q_reg <= iter_mem[slot_reg];
            inv_q_reg  <= inv_mem[slot_reg];
            last_q_reg <= last_mem[slot_reg];
            mean_q_reg <= mean_mem[slot_reg];
            chg_q_reg  <= chg_mem[slot_reg];
        end
        if (cmd.commit && (kind_reg != STATUS_DROP))
        begin
            seen_mem[slot_reg] <= seen_n_reg;
            iter_mem[slot_reg] <= iter_n_reg;
            inv_mem[slot_reg]  <= inv_n_reg;
            last_mem[slot_reg] <= last_n_reg;
            mean_mem[slot_reg] <= mean_new;
            chg_mem[slot_reg]  <= chg_n_reg;
            if (kind_reg == STATUS_ALLOC)
                tag_mem[slot_reg] <= addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            seen_n_reg <= sat_inc(seen_b);
            mean_o_reg <= mean_b;
            ge_reg     <= ge;
            if (taken_reg)
            begin
                iter_n_reg <= iter_inc;
                inv_n_reg  <= inv_b;
                last_n_reg <= last_b;
                chg_n_reg  <= chg_b;
            end
            else
            begin
                iter_n_reg <= '0;
                inv_n_reg  <= inv_inc;
                last_n_reg <= iter_inc;
                chg_n_reg  <= chg_inc;
            end
        end
    end

    assign slot_ext = 8'(slot_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (kind_reg == STATUS_DROP)
            begin
                out_reg <= drop_item;
            end
            else
            begin
                out_reg.status        <= kind_reg;
                out_reg.slot          <= slot_ext[3:0];
                out_reg.seen_count    <= to_out(seen_n_reg);
                out_reg.invocations   <= to_out(inv_n_reg);
                out_reg.mean_trips    <= to_out(mean_new);
                out_reg.change_count  <= to_out(chg_n_reg);
                out_reg.trip_count    <= to_out(last_n_reg);
                out_reg.running_iters <= to_out(iter_n_reg);
            end
        end
    end

    assign out_data = out_reg;

endmodule

// File: rtl/lbp_ctrl.sv
// Profiler controller: sequences scan, read, update, divide and commit,
// and owns the input ready and result valid. Depends on lbp_pkg.

module lbp_ctrl
    import lbp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  lbp_sts_t sts,
    output lbp_cmd_t cmd
);

    lbp_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                    state_next = ST_READ;
                else if (sts.miss)
                    state_next = sts.full ? ST_FINISH : ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = sts.need_div ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // result register must be free or emptying this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sim/loop_branch_profiler_core_tb.sv
`timescale 1ns / 100ps
// Testbench for loop_branch_profiler_core: sends branch events, predicts each
// profile record in the bench and compares it field by field.
// Depends on lbp_pkg and the profiler RTL.

module loop_branch_profiler_core_tb;
    import lbp_pkg::*;

    localparam int NUM_SLOTS    = ENTRIES_DEF;
    localparam int TOTAL_ITEMS  = 1750;
    localparam int STALL_LIMIT  = 4000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 40;
    localparam logic [OUT_CNT_W-1:0] CNT_MAX = '1;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    loop_branch_profiler_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Bench copy of the loop table. Slots are never freed, so valid_mem
    // only ever goes from 0 to 1.
    // ------------------------------------------------------------------
    logic [IN_ADDR_W-1:0] tag_mem    [NUM_SLOTS];
    bit                   valid_mem  [NUM_SLOTS];
    logic [OUT_CNT_W-1:0] iter_cnt   [NUM_SLOTS];
    logic [OUT_CNT_W-1:0] last_trip  [NUM_SLOTS];
    logic [OUT_CNT_W-1:0] inv_cnt    [NUM_SLOTS];
    logic [OUT_CNT_W-1:0] seen_cnt   [NUM_SLOTS];
    logic [OUT_CNT_W-1:0] mean_val   [NUM_SLOTS];
    logic [OUT_CNT_W-1:0] change_cnt [NUM_SLOTS];

    out_item_t pending_profiles [$];   // predicted records, oldest first
    out_item_t oldest_profile;

    // Loop addresses the stimulus works on; entry k lands in slot k because
    // the directed tests allocate them in order.
    logic [IN_ADDR_W-1:0] loop_addr   [NUM_SLOTS];
    int                   loop_target [NUM_SLOTS];

    int error_count  = 0;
    int items_sent   = 0;
    int hit_count    = 0;
    int alloc_count  = 0;
    int drop_count   = 0;
    int exit_count   = 0;
    int idle_cycles  = 0;
    bit no_idle;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [OUT_CNT_W-1:0] sat_inc(input logic [OUT_CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Running mean moved toward the new trip count; rounds toward the trip
    // on the way down so the mean equals floor of the true weighted value.
    function automatic logic [OUT_CNT_W-1:0] mean_step(input logic [OUT_CNT_W-1:0] m,
                                                       input logic [OUT_CNT_W-1:0] t,
                                                       input logic [OUT_CNT_W-1:0] n);
        logic [OUT_CNT_W-1:0] d;
        logic [OUT_CNT_W-1:0] div;
        div = (n == 0) ? 1 : n;
        if (t >= m)
            return m + (t - m) / div;
        d = m - t;
        return m - (d / div + ((d % div) != 0 ? 1 : 0));
    endfunction

    function automatic out_item_t profile_branch(input in_item_t item);
        out_item_t            rec;
        int                   s;
        bit                   found;
        logic [OUT_CNT_W-1:0] trip;
        rec   = '0;
        s     = 0;
        found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!found && valid_mem[i] && tag_mem[i] == item.branch_addr)
            begin
                s     = i;
                found = 1'b1;
            end
        if (found)
        begin
            rec.status = STATUS_HIT;
            hit_count++;
        end
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                if (!found && !valid_mem[i])
                begin
                    s     = i;
                    found = 1'b1;
                end
            // table full: flagged record, all counters zero, nothing changes
            if (!found)
            begin
                rec.status = STATUS_DROP;
                drop_count++;
                return rec;
            end
            valid_mem[s]  = 1'b1;
            tag_mem[s]    = item.branch_addr;
            iter_cnt[s]   = '0;
            last_trip[s]  = '0;
            inv_cnt[s]    = '0;
            seen_cnt[s]   = '0;
            mean_val[s]   = '0;
            change_cnt[s] = '0;
            rec.status    = STATUS_ALLOC;
            alloc_count++;
        end

        seen_cnt[s] = sat_inc(seen_cnt[s]);
        iter_cnt[s] = sat_inc(iter_cnt[s]);
        if (!item.taken)
        begin
            // loop exit closes one invocation
            trip = iter_cnt[s];
            if (last_trip[s] != trip && last_trip[s] != 0)
                change_cnt[s] = sat_inc(change_cnt[s]);
            inv_cnt[s]   = sat_inc(inv_cnt[s]);
            last_trip[s] = trip;
            iter_cnt[s]  = '0;
            mean_val[s]  = mean_step(mean_val[s], trip, inv_cnt[s]);
            exit_count++;
        end

        rec.slot          = s[3:0];
        rec.seen_count    = seen_cnt[s];
        rec.invocations   = inv_cnt[s];
        rec.mean_trips    = mean_val[s];
        rec.change_count  = change_cnt[s];
        rec.trip_count    = last_trip[s];
        rec.running_iters = iter_cnt[s];
        return rec;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic bit is_pool_addr(input logic [IN_ADDR_W-1:0] addr);
        for (int k = 0; k < NUM_SLOTS; k++)
            if (loop_addr[k] === addr)
                return 1'b1;
        return 1'b0;
    endfunction

    // random address that belongs to none of the tracked loops
    function automatic logic [IN_ADDR_W-1:0] random_new_addr();
        logic [63:0] wide;
        do
            wide = {$urandom, $urandom};
        while (is_pool_addr(wide[IN_ADDR_W-1:0]));
        return wide[IN_ADDR_W-1:0];
    endfunction

    // idle cycles between items: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(200, 30);
    endfunction

    // Drive one branch event at the falling edge, hold it until accepted,
    // then record the predicted profile. Valid stays high when no gap follows.
    task automatic send_branch(input logic [IN_ADDR_W-1:0] addr, input logic tk);
        in_item_t item;
        int       gap;
        item.branch_addr = addr;
        item.taken       = tk;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        pending_profiles.push_back(profile_branch(item));
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, none while no_idle is set
    // ------------------------------------------------------------------
    initial
    begin : sink_driver
        int hold;
        int r;
        hold      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (no_idle)
                out_ready <= 1'b1;
            else if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 65)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    hold = (r < 93) ? $urandom_range(2, 0) : $urandom_range(150, 20);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [OUT_CNT_W-1:0] want,
                               input logic [OUT_CNT_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_profiles.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected record, expected none, got status %0d slot %0d",
                             $time, out_data.status, out_data.slot);
            end
            else
            begin
                oldest_profile = pending_profiles.pop_front();
                check_field("status",        OUT_CNT_W'(oldest_profile.status),
                            OUT_CNT_W'(out_data.status));
                check_field("slot",          OUT_CNT_W'(oldest_profile.slot),
                            OUT_CNT_W'(out_data.slot));
                check_field("seen_count",    oldest_profile.seen_count,    out_data.seen_count);
                check_field("invocations",   oldest_profile.invocations,   out_data.invocations);
                check_field("mean_trips",    oldest_profile.mean_trips,    out_data.mean_trips);
                check_field("change_count",  oldest_profile.change_count,  out_data.change_count);
                check_field("trip_count",    oldest_profile.trip_count,    out_data.trip_count);
                check_field("running_iters", oldest_profile.running_iters,
                            out_data.running_iters);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no item moving on either channel for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no progress for %0d cycles, %0d records outstanding",
                     $time, STALL_LIMIT, pending_profiles.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Allocation, exit on the allocating event, equal and changed trip
    // counts, and the mean moving both down and up.
    task automatic test_loop_exits();
        for (int k = 0; k < NUM_SLOTS; k++)
            loop_addr[k] = '0;
        loop_addr[1] = '1;
        loop_addr[2] = 48'hAAAA_AAAA_AAAA;
        loop_addr[3] = 48'h5555_5555_5555;
        for (int k = 4; k < NUM_SLOTS; k++)
            loop_addr[k] = random_new_addr();

        // address zero: allocate, iterate, exit with trip 3
        send_branch(loop_addr[0], 1'b1);
        send_branch(loop_addr[0], 1'b1);
        send_branch(loop_addr[0], 1'b0);
        // all-ones address exits on its allocating event, then again: same trip
        send_branch(loop_addr[1], 1'b0);
        send_branch(loop_addr[1], 1'b0);
        // shorter trip: change counted, mean rounds down toward it
        send_branch(loop_addr[0], 1'b1);
        send_branch(loop_addr[0], 1'b0);
        // longer trip: mean moves up
        repeat (4) send_branch(loop_addr[0], 1'b1);
        send_branch(loop_addr[0], 1'b0);
    endtask

    // Fill every remaining slot, then events for unknown loops are dropped.
    task automatic test_table_fill();
        for (int k = 2; k < NUM_SLOTS; k++)
            send_branch(loop_addr[k], k[0]);
        send_branch(random_new_addr(), 1'b1);
        send_branch(random_new_addr(), 1'b0);
    endtask

    // Mostly well-formed loops with random trip counts, interleaved as
    // nested loops would be, plus early exits and unknown-loop noise.
    task automatic test_random_loops();
        int cur;
        int r;
        cur = 0;
        for (int k = 0; k < NUM_SLOTS; k++)
            loop_target[k] = $urandom_range(8, 1);
        while (items_sent < TOTAL_ITEMS)
        begin
            // some stretches run with no idling on either side
            if (items_sent % 100 == 0)
                no_idle = ($urandom_range(4) == 0);
            r = $urandom_range(99);
            if (r < 5)
                send_branch(random_new_addr(), 1'($urandom_range(1)));
            else if (r < 9)
                send_branch(loop_addr[$urandom_range(NUM_SLOTS - 1)], 1'b0);
            else
            begin
                if ($urandom_range(99) < 30)
                    cur = $urandom_range(NUM_SLOTS - 1);
                if (iter_cnt[cur] + 1 >= loop_target[cur])
                begin
                    send_branch(loop_addr[cur], 1'b0);
                    // keep the trip count often, so both equal and changed trips occur
                    if ($urandom_range(99) < 35)
                        loop_target[cur] = ($urandom_range(9) == 0) ?
                                           $urandom_range(60, 13) : $urandom_range(12, 1);
                end
                else
                    send_branch(loop_addr[cur], 1'b1);
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        no_idle  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_loop_exits();
        test_table_fill();
        test_random_loops();

        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_profiles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d branch events: %0d hits, %0d allocations, %0d drops, %0d loop exits",
                 items_sent, hit_count, alloc_count, drop_count, exit_count);
        $display("Field mismatches: %0d, records never received: %0d",
                 error_count, pending_profiles.size());
        if (error_count == 0 && pending_profiles.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: loop_branch_profiler_core.f
rtl/lbp_pkg.sv
rtl/lbp_divider.sv
rtl/lbp_datapath.sv
rtl/lbp_ctrl.sv
rtl/loop_branch_profiler_core.sv
sim/loop_branch_profiler_core_tb.sv
